FILE: sv/osl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osl_pkg
// Widths, cell word type and saturation helper for the OSL error term solver.
// ----------------------------------------------------------------------------
package osl_pkg;

	localparam int NUM_W = 49;
	localparam int DIV_W = 34;
	localparam int SCALE = 1000;

	// divide by 1000 as a row of 16-bit digit cells
	localparam int             DEC_N     = 4;
	localparam int             DEC_W     = 64;
	localparam logic [26:0]    DEC_RECIP = 27'd68719477;

	typedef struct packed {
		logic signed [15:0] l_re;
		logic signed [15:0] l_im;
		logic signed [16:0] a_re;
		logic signed [16:0] a_im;
		logic signed [31:0] e11_re;
		logic signed [31:0] e11_im;
		logic               sgn_re;
		logic               sgn_im;
		logic               degen;
	} side_t;

	typedef struct packed {
		logic             valid;
		logic [DIV_W-1:0] rem_re;
		logic [NUM_W-1:0] nq_re;
		logic [DIV_W-1:0] rem_im;
		logic [NUM_W-1:0] nq_im;
		logic [DIV_W-1:0] div;
		side_t            side;
	} cell_t;

	function automatic logic [31:0] sat32(input logic [NUM_W:0] v);
		logic [31:0] r;
		if ((&v[NUM_W:31]) || (~|v[NUM_W:31]))
			r = v[31:0];
		else if (v[NUM_W])
			r = 32'h8000_0000;
		else
			r = 32'h7fff_ffff;
		return r;
	endfunction

	function automatic logic [31:0] signed_sat(input logic sgn, input logic [NUM_W-1:0] mag);
		logic [NUM_W:0] v;
		v = sgn ? ((NUM_W+1)'(0) - {1'b0, mag}) : {1'b0, mag};
		return sat32(v);
	endfunction

	// one digit of the divide by 1000: returns {quotient digit, remainder}
	function automatic logic [25:0] dec_step(input logic [9:0] rem, input logic [15:0] digit);
		logic [25:0] t;
		logic [52:0] p;
		logic [15:0] qd;
		logic [25:0] back;
		t    = {rem, digit};
		p    = 53'(t) * 53'(DEC_RECIP);
		qd   = 16'(p >> 36);
		back = 26'(qd) * 26'(SCALE);
		return {qd, 10'(t - back)};
	endfunction

endpackage

FILE: sv/osl_error_term_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osl_error_term_solver
// One-port OSL error terms: e00, e11 by complex division, delta_e.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready   | open, short, load (re, im)
//   out     | out_valid / out_ready | directivity, source_match, delta, degenerate
//
// One word per cycle while the output is not stalled; the row is 4 front stages, 49 cells of the
// e11 divider, 4 stages for delta_e, 4 digit cells of the divide by 1000 and the
// output. Reset clears only the valid flags. A stalled output holds the whole row.
// ----------------------------------------------------------------------------
module osl_error_term_solver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] open_re,
	input  logic signed [15:0] open_im,
	input  logic signed [15:0] short_re,
	input  logic signed [15:0] short_im,
	input  logic signed [15:0] load_re,
	input  logic signed [15:0] load_im,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] directivity_re,
	output logic signed [15:0] directivity_im,
	output logic signed [31:0] source_match_re,
	output logic signed [31:0] source_match_im,
	output logic signed [31:0] delta_re,
	output logic signed [31:0] delta_im,
	output logic               degenerate
);
	import osl_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, out_valid_q;

	logic signed [16:0] d_re_s1, d_im_s1, a_re_s1, a_im_s1;
	logic signed [17:0] n_re_s1, n_im_s1;
	logic signed [15:0] l_re_s1, l_im_s1;

	logic signed [34:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [33:0] qr_s2, qi_s2;
	logic signed [16:0] a_re_s2, a_im_s2;
	logic signed [15:0] l_re_s2, l_im_s2;

	logic signed [35:0] num_re_s3, num_im_s3;
	logic signed [34:0] q_s3;
	logic signed [16:0] a_re_s3, a_im_s3;
	logic signed [15:0] l_re_s3, l_im_s3;

	logic [35:0]      mag_re, mag_im;
	logic [NUM_W-1:0] nm_re_s4, nm_im_s4;
	logic [DIV_W-1:0] q_s4;
	side_t            side_s4;

	cell_t c1_in, c1_out;

	logic signed [31:0] e11_re_s5, e11_im_s5;
	side_t              side_s5;

	logic signed [32:0] b_re, b_im;
	logic signed [49:0] m1_s6, m2_s6, m3_s6, m4_s6;
	side_t              side_n6, side_s6;

	logic signed [50:0] sum_re_s7, sum_im_s7;
	side_t              side_s7;

	logic [50:0]      abs_re, abs_im;
	logic [NUM_W-1:0] nm_re_s8, nm_im_s8;
	side_t            side_n8, side_s8;

	logic [DEC_N-1:0] dec_valid_q;
	logic [9:0]       dec_rem_re_q [DEC_N];
	logic [9:0]       dec_rem_im_q [DEC_N];
	logic [DEC_W-1:0] dec_nq_re_q [DEC_N];
	logic [DEC_W-1:0] dec_nq_im_q [DEC_N];
	side_t            dec_side_q [DEC_N];
	logic [9:0]       dr_re_in [DEC_N];
	logic [9:0]       dr_im_in [DEC_N];
	logic [DEC_W-1:0] dn_re_in [DEC_N];
	logic [DEC_W-1:0] dn_im_in [DEC_N];
	logic [25:0]      ds_re [DEC_N];
	logic [25:0]      ds_im [DEC_N];
	side_t            dec_last;

	logic signed [15:0] dir_re_q, dir_im_q;
	logic signed [31:0] sm_re_q, sm_im_q, de_re_q, de_im_q;
	logic               degen_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			dec_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= c1_out.valid;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			dec_valid_q <= {dec_valid_q[DEC_N-2:0], v_s8};
			out_valid_q <= dec_valid_q[DEC_N-1];
		end
	end

	always_comb begin
		mag_re = num_re_s3[35] ? 36'(-num_re_s3) : 36'(num_re_s3);
		mag_im = num_im_s3[35] ? 36'(-num_im_s3) : 36'(num_im_s3);
		b_re   = 33'(SCALE) - 33'(e11_re_s5);
		b_im   = 33'(0) - 33'(e11_im_s5);
		abs_re = sum_re_s7[50] ? 51'(-sum_re_s7) : 51'(sum_re_s7);
		abs_im = sum_im_s7[50] ? 51'(-sum_im_s7) : 51'(sum_im_s7);
		side_n6        = side_s5;
		side_n6.e11_re = e11_re_s5;
		side_n6.e11_im = e11_im_s5;
		side_n8        = side_s7;
		side_n8.sgn_re = sum_re_s7[50];
		side_n8.sgn_im = sum_im_s7[50];
	end

	// digit cells of the divide by 1000
	always_comb begin
		dr_re_in[0] = '0;
		dr_im_in[0] = '0;
		dn_re_in[0] = DEC_W'(nm_re_s8);
		dn_im_in[0] = DEC_W'(nm_im_s8);
		for (int k = 1; k < DEC_N; k++) begin
			dr_re_in[k] = dec_rem_re_q[k-1];
			dr_im_in[k] = dec_rem_im_q[k-1];
			dn_re_in[k] = dec_nq_re_q[k-1];
			dn_im_in[k] = dec_nq_im_q[k-1];
		end
		for (int k = 0; k < DEC_N; k++) begin
			ds_re[k] = dec_step(dr_re_in[k], dn_re_in[k][DEC_W-1:DEC_W-16]);
			ds_im[k] = dec_step(dr_im_in[k], dn_im_in[k][DEC_W-1:DEC_W-16]);
		end
		dec_last = dec_side_q[DEC_N-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// front: differences
			d_re_s1 <= 17'(open_re) - 17'(short_re);
			d_im_s1 <= 17'(open_im) - 17'(short_im);
			n_re_s1 <= 18'(open_re) + 18'(short_re) - 18'(load_re) - 18'(load_re);
			n_im_s1 <= 18'(open_im) + 18'(short_im) - 18'(load_im) - 18'(load_im);
			a_re_s1 <= 17'(open_re) - 17'(load_re);
			a_im_s1 <= 17'(open_im) - 17'(load_im);
			l_re_s1 <= load_re;
			l_im_s1 <= load_im;
			// products
			pa_s2   <= 35'(n_re_s1) * 35'(d_re_s1);
			pb_s2   <= 35'(n_im_s1) * 35'(d_im_s1);
			pc_s2   <= 35'(n_im_s1) * 35'(d_re_s1);
			pd_s2   <= 35'(n_re_s1) * 35'(d_im_s1);
			qr_s2   <= 34'(d_re_s1) * 34'(d_re_s1);
			qi_s2   <= 34'(d_im_s1) * 34'(d_im_s1);
			a_re_s2 <= a_re_s1;
			a_im_s2 <= a_im_s1;
			l_re_s2 <= l_re_s1;
			l_im_s2 <= l_im_s1;
			// sums
			num_re_s3 <= 36'(pa_s2) + 36'(pb_s2);
			num_im_s3 <= 36'(pc_s2) - 36'(pd_s2);
			q_s3      <= 35'(qr_s2) + 35'(qi_s2);
			a_re_s3   <= a_re_s2;
			a_im_s3   <= a_im_s2;
			l_re_s3   <= l_re_s2;
			l_im_s3   <= l_im_s2;
			// scale and split sign
			nm_re_s4       <= NUM_W'(NUM_W'(mag_re) * NUM_W'(SCALE));
			nm_im_s4       <= NUM_W'(NUM_W'(mag_im) * NUM_W'(SCALE));
			q_s4           <= q_s3[DIV_W-1:0];
			side_s4.l_re   <= l_re_s3;
			side_s4.l_im   <= l_im_s3;
			side_s4.a_re   <= a_re_s3;
			side_s4.a_im   <= a_im_s3;
			side_s4.e11_re <= '0;
			side_s4.e11_im <= '0;
			side_s4.sgn_re <= num_re_s3[35];
			side_s4.sgn_im <= num_im_s3[35];
			side_s4.degen  <= (q_s3 == '0);
			// e11
			e11_re_s5 <= c1_out.side.degen ? '0 :
				signed_sat(c1_out.side.sgn_re, c1_out.nq_re);
			e11_im_s5 <= c1_out.side.degen ? '0 :
				signed_sat(c1_out.side.sgn_im, c1_out.nq_im);
			side_s5   <= c1_out.side;
			// delta products
			m1_s6   <= 50'(side_s5.a_re) * 50'(b_re);
			m2_s6   <= 50'(side_s5.a_im) * 50'(b_im);
			m3_s6   <= 50'(side_s5.a_re) * 50'(b_im);
			m4_s6   <= 50'(side_s5.a_im) * 50'(b_re);
			side_s6 <= side_n6;
			// delta sums
			sum_re_s7 <= 51'(m1_s6) - 51'(m2_s6);
			sum_im_s7 <= 51'(m3_s6) + 51'(m4_s6);
			side_s7   <= side_s6;
			// split sign
			nm_re_s8 <= abs_re[NUM_W-1:0];
			nm_im_s8 <= abs_im[NUM_W-1:0];
			side_s8  <= side_n8;
			// divide by 1000, one digit per cell
			for (int k = 0; k < DEC_N; k++) begin
				dec_rem_re_q[k] <= ds_re[k][9:0];
				dec_rem_im_q[k] <= ds_im[k][9:0];
				dec_nq_re_q[k]  <= {dn_re_in[k][DEC_W-17:0], ds_re[k][25:10]};
				dec_nq_im_q[k]  <= {dn_im_in[k][DEC_W-17:0], ds_im[k][25:10]};
				dec_side_q[k]   <= (k == 0) ? side_s8 : dec_side_q[k == 0 ? 0 : k-1];
			end
			// output word
			dir_re_q <= dec_last.l_re;
			dir_im_q <= dec_last.l_im;
			sm_re_q  <= dec_last.e11_re;
			sm_im_q  <= dec_last.e11_im;
			de_re_q  <= dec_last.degen ? '0 :
				signed_sat(dec_last.sgn_re, dec_nq_re_q[DEC_N-1][NUM_W-1:0]);
			de_im_q  <= dec_last.degen ? '0 :
				signed_sat(dec_last.sgn_im, dec_nq_im_q[DEC_N-1][NUM_W-1:0]);
			degen_q  <= dec_last.degen;
		end
	end

	always_comb begin
		c1_in.valid  = v_s4;
		c1_in.rem_re = '0;
		c1_in.nq_re  = nm_re_s4;
		c1_in.rem_im = '0;
		c1_in.nq_im  = nm_im_s4;
		c1_in.div    = q_s4;
		c1_in.side   = side_s4;
	end

	osl_div_chain u_e11_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.c_in   (c1_in),
		.c_out  (c1_out)
	);

	assign out_valid       = out_valid_q;
	assign directivity_re  = dir_re_q;
	assign directivity_im  = dir_im_q;
	assign source_match_re = sm_re_q;
	assign source_match_im = sm_im_q;
	assign delta_re        = de_re_q;
	assign delta_im        = de_im_q;
	assign degenerate      = degen_q;

endmodule

FILE: sv/osl_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osl_div_cell
// One restoring division step on two lanes; hands the word to the next cell.
// ----------------------------------------------------------------------------
module osl_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  osl_pkg::cell_t c_in,
	output osl_pkg::cell_t c_out
);
	import osl_pkg::*;

	logic [DIV_W:0]   trial_re, trial_im;
	logic             ge_re, ge_im;
	logic [DIV_W-1:0] rem_re_n, rem_im_n;
	logic             valid_q;
	cell_t            word_q;

	always_comb begin
		trial_re = {c_in.rem_re, c_in.nq_re[NUM_W-1]};
		trial_im = {c_in.rem_im, c_in.nq_im[NUM_W-1]};
		ge_re    = trial_re >= {1'b0, c_in.div};
		ge_im    = trial_im >= {1'b0, c_in.div};
		rem_re_n = ge_re ? DIV_W'(trial_re - {1'b0, c_in.div}) : trial_re[DIV_W-1:0];
		rem_im_n = ge_im ? DIV_W'(trial_im - {1'b0, c_in.div}) : trial_im[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= c_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q.valid  <= 1'b0;
			word_q.rem_re <= rem_re_n;
			word_q.nq_re  <= {c_in.nq_re[NUM_W-2:0], ge_re};
			word_q.rem_im <= rem_im_n;
			word_q.nq_im  <= {c_in.nq_im[NUM_W-2:0], ge_im};
			word_q.div    <= c_in.div;
			word_q.side   <= c_in.side;
		end
	end

	always_comb begin
		c_out       = word_q;
		c_out.valid = valid_q;
	end

endmodule

FILE: sv/osl_div_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osl_div_chain
// Row of division cells, one quotient bit per cell, one word per cycle while en is high.
// ----------------------------------------------------------------------------
module osl_div_chain (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  osl_pkg::cell_t c_in,
	output osl_pkg::cell_t c_out
);
	import osl_pkg::*;

	cell_t link [NUM_W+1];

	assign link[0] = c_in;

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		osl_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.c_in   (link[i]),
			.c_out  (link[i+1])
		);
	end

	assign c_out = link[NUM_W];

endmodule

FILE: sv/osl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osl_checker
// Port-level checks on the OSL error term solver, bound to the top level.
// ----------------------------------------------------------------------------
module osl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] source_match_re,
	input logic signed [31:0] source_match_im,
	input logic signed [31:0] delta_re,
	input logic signed [31:0] delta_im,
	input logic               degenerate
);

	a_hold_valid : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_hold_word : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(delta_re) && $stable(source_match_re))
		else $error("output word changed while stalled");

	a_stall_back : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_degen_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> source_match_re == 0 && source_match_im == 0
			&& delta_re == 0 && delta_im == 0)
		else $error("degenerate word carries nonzero terms");

endmodule

bind osl_error_term_solver osl_checker u_osl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.source_match_re (source_match_re),
	.source_match_im (source_match_im),
	.delta_re        (delta_re),
	.delta_im        (delta_im),
	.degenerate      (degenerate)
);

FILE: sim/osl_error_term_solver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osl_error_term_solver_test
// Drives open/short/load words through the solver with random idling and a
// long output hold-off, predicts e00, e11 and delta_e in 64-bit integer
// arithmetic and checks every returned word in order.
// ----------------------------------------------------------------------------
module osl_error_term_solver_test;

	typedef struct {
		logic signed [15:0] o_re, o_im, s_re, s_im, l_re, l_im;
	} osl_word_t;

	typedef struct {
		logic signed [15:0] dir_re, dir_im;
		logic signed [31:0] sm_re, sm_im, dl_re, dl_im;
		logic               degen;
	} terms_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               in_ready_q = 1'b0;
	logic signed [15:0] open_re = '0, open_im = '0, short_re = '0, short_im = '0;
	logic signed [15:0] load_re = '0, load_im = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] directivity_re, directivity_im;
	logic signed [31:0] source_match_re, source_match_im, delta_re, delta_im;
	logic               degenerate;

	osl_word_t pending_words[$];
	terms_t    expected_terms[$];
	int        mismatches = 0;
	int        cycle_no = 0;
	bit        stim_done = 0;

	osl_error_term_solver u_dut (.*);

	always #5 clk = ~clk;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic terms_t solve_terms(osl_word_t w);
		terms_t t;
		longint n_re, n_im, d_re, d_im, q, a_re, a_im, b_re, b_im, e_re, e_im;
		n_re = longint'(w.o_re) + w.s_re - 2 * longint'(w.l_re);
		n_im = longint'(w.o_im) + w.s_im - 2 * longint'(w.l_im);
		d_re = longint'(w.o_re) - w.s_re;
		d_im = longint'(w.o_im) - w.s_im;
		q = d_re * d_re + d_im * d_im;
		t.dir_re = w.l_re;
		t.dir_im = w.l_im;
		t.degen = (q == 0);
		t.sm_re = '0; t.sm_im = '0; t.dl_re = '0; t.dl_im = '0;
		if (q != 0) begin
			e_re = clamp32((1000 * (n_re * d_re + n_im * d_im)) / q);
			e_im = clamp32((1000 * (n_im * d_re - n_re * d_im)) / q);
			a_re = longint'(w.o_re) - w.l_re;
			a_im = longint'(w.o_im) - w.l_im;
			b_re = 1000 - e_re;
			b_im = -e_im;
			t.sm_re = e_re[31:0];
			t.sm_im = e_im[31:0];
			t.dl_re = 32'(clamp32((a_re * b_re - a_im * b_im) / 1000));
			t.dl_im = 32'(clamp32((a_re * b_im + a_im * b_re) / 1000));
		end
		return t;
	endfunction

	function automatic logic signed [15:0] pick16();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(0, 2000)) - 1000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_word(input logic signed [15:0] ore, oim, sre, sim, lre, lim);
		osl_word_t w;
		w.o_re = ore; w.o_im = oim; w.s_re = sre; w.s_im = sim;
		w.l_re = lre; w.l_im = lim;
		pending_words.push_back(w);
	endtask

	initial begin
		osl_word_t w;
		push_word(16'sh7fff, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
		push_word(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
		push_word(16'sd1000, 16'sd0, -16'sd1000, 16'sd0, 16'sd0, 16'sd0);
		push_word(16'sd1000, 16'sd0, -16'sd1000, 16'sd0, 16'sh7fff, 16'sh7fff);
		push_word(16'sd500, 16'sd300, 16'sd500, 16'sd300, 16'sd123, -16'sd45);
		push_word(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		push_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		push_word(16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh8000);
		push_word(16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000);
		push_word(16'sh7fff, 16'sh7fff, 16'sh7ffe, 16'sh7fff, 16'sh8000, 16'sh8000);
		push_word(-16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff);
		push_word(16'sd980, -16'sd15, -16'sd995, 16'sd20, 16'sd12, -16'sd3);
		for (int i = 0; i < 1400; i++) begin
			w.o_re = pick16(); w.o_im = pick16();
			w.l_re = pick16(); w.l_im = pick16();
			if ($urandom_range(0, 19) == 0) begin
				w.s_re = w.o_re; w.s_im = w.o_im;
			end else if ($urandom_range(0, 9) == 0) begin
				w.s_re = w.o_re + 16'($urandom_range(0, 2)) - 16'sd1;
				w.s_im = w.o_im + 16'($urandom_range(0, 2)) - 16'sd1;
			end else begin
				w.s_re = pick16(); w.s_im = pick16();
			end
			pending_words.push_back(w);
		end
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// sender: idle about 36 in 100, no idling in cycles 1000..1600
	always @(negedge clk) begin
		cycle_no <= cycle_no + 1;
		if (arst_n && !(in_valid && !in_ready_q)) begin
			if (pending_words.size() != 0 &&
			    ((cycle_no >= 1000 && cycle_no < 1600) || $urandom_range(0, 99) >= 36)) begin
				osl_word_t w;
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				open_re <= w.o_re; open_im <= w.o_im;
				short_re <= w.s_re; short_im <= w.s_im;
				load_re <= w.l_re; load_im <= w.l_im;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// accepted flag from the last rising edge
	always @(posedge clk) begin
		in_ready_q <= in_ready;
		if (arst_n && in_valid && in_ready) begin
			osl_word_t w;
			w.o_re = open_re; w.o_im = open_im; w.s_re = short_re;
			w.s_im = short_im; w.l_re = load_re; w.l_im = load_im;
			expected_terms.push_back(solve_terms(w));
		end
	end

	// receiver: long hold-off early, then random stalls, none in the window where the sender does not idle
	int hold_count = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_count < 400) begin
			hold_count <= hold_count + 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (cycle_no >= 1000 && cycle_no < 1600) ||
				($urandom_range(0, 99) >= 36);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			terms_t e;
			if (expected_terms.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10) $display("unexpected word at %0t", $realtime);
			end else begin
				e = expected_terms.pop_front();
				if (directivity_re !== e.dir_re || directivity_im !== e.dir_im ||
				    source_match_re !== e.sm_re || source_match_im !== e.sm_im ||
				    delta_re !== e.dl_re || delta_im !== e.dl_im ||
				    degenerate !== e.degen) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0d %0d %0b",
							e.dir_re, e.dir_im, e.sm_re, e.sm_im, e.dl_re, e.dl_im, e.degen,
							directivity_re, directivity_im, source_match_re,
							source_match_im, delta_re, delta_im, degenerate);
				end
			end
		end
	end

	initial begin
		wait (arst_n);
		wait (pending_words.size() == 0);
		@(posedge clk);
		while (in_valid && !in_ready) @(posedge clk);
		repeat (2) @(posedge clk);
		while (expected_terms.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
